[rtl/mvm_pkg.sv]
`default_nettype none

package mvm_pkg;

   localparam int VECTOR_DEPTH   = 1024;
   localparam int ELEMENT_WIDTH  = 16;
   localparam int ADDR_WIDTH     = $clog2(VECTOR_DEPTH);
   localparam int COL_WIDTH      = 11;
   localparam int ROW_WIDTH      = 16;
   localparam int SUM_WIDTH      = 42;
   localparam int PROD_WIDTH     = 2 * ELEMENT_WIDTH;
   localparam int CSR_DATA_WIDTH = 16;

   typedef enum logic [0:0] {
      CSR_COLUMN_COUNT = 1'b0,
      CSR_ROW_COUNT    = 1'b1
   } csr_index_type;

   typedef enum logic [0:0] {
      CMD_LOAD   = 1'b0,
      CMD_MATRIX = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type                          cmd;
      logic signed [ELEMENT_WIDTH-1:0]  value;
   } req_type;

   typedef struct packed {
      logic signed [SUM_WIDTH-1:0]  row_sum;
      logic [ROW_WIDTH-1:0]         row_index;
      logic                         last_row;
   } rsp_type;

   typedef struct packed {
      logic                  last_col;
      logic [ROW_WIDTH-1:0]  row_index;
      logic                  last_row;
   } tag_type;

   function automatic logic [ADDR_WIDTH-1:0] last_column(input logic [COL_WIDTH-1:0] count);
      int c;
      c = int'(count);
      if (c == 0) c = 1;
      if (c > VECTOR_DEPTH) c = VECTOR_DEPTH;
      c = c - 1;
      return c[ADDR_WIDTH-1:0];
   endfunction

   function automatic logic [ROW_WIDTH-1:0] last_row_index(input logic [ROW_WIDTH-1:0] count);
      return (count == '0) ? '0 : count - ROW_WIDTH'(1);
   endfunction

endpackage

`default_nettype wire

[rtl/mvm_ram.sv]
`default_nettype none

module mvm_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 16
) (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire logic [WIDTH-1:0]          wr_data,
   input  wire logic                      rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]               rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/mvm_seq.sv]
`default_nettype none

module mvm_seq import mvm_pkg::*; (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         accept,
   input  wire logic                         advance,
   input  wire req_type                      req,
   input  wire logic                         csr_we,
   input  wire csr_index_type                csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]    csr_wdata,
   output logic                              wr_en,
   output logic [ADDR_WIDTH-1:0]             wr_addr,
   output logic [ELEMENT_WIDTH-1:0]          wr_data,
   output logic                              rd_en,
   output logic [ADDR_WIDTH-1:0]             rd_addr,
   output logic                              s1_valid,
   output logic signed [ELEMENT_WIDTH-1:0]   s1_value,
   output tag_type                           s1_tag
);

   logic [COL_WIDTH-1:0]            column_count_ff;
   logic [ROW_WIDTH-1:0]            row_count_ff;
   logic [ADDR_WIDTH-1:0]           load_pos_ff, load_pos_in;
   logic [ADDR_WIDTH-1:0]           col_pos_ff, col_pos_in;
   logic [ROW_WIDTH-1:0]            row_pos_ff, row_pos_in;
   logic                            s1_valid_ff;
   logic signed [ELEMENT_WIDTH-1:0] s1_value_ff;
   tag_type                         s1_tag_ff, s1_tag_in;
   logic [ADDR_WIDTH-1:0]           cols_last;
   logic [ROW_WIDTH-1:0]            rows_last;
   logic                            load_beat, matrix_beat;

   assign cols_last   = last_column(column_count_ff);
   assign rows_last   = last_row_index(row_count_ff);
   assign load_beat   = accept && (req.cmd == CMD_LOAD);
   assign matrix_beat = accept && (req.cmd == CMD_MATRIX);

   always_comb begin
      load_pos_in = load_pos_ff;
      col_pos_in  = col_pos_ff;
      row_pos_in  = row_pos_ff;
      s1_tag_in.last_col  = (col_pos_ff == cols_last);
      s1_tag_in.row_index = row_pos_ff;
      s1_tag_in.last_row  = (row_pos_ff == rows_last);
      if (load_beat) begin
         load_pos_in = (load_pos_ff == cols_last) ? '0 : load_pos_ff + ADDR_WIDTH'(1);
      end
      if (matrix_beat) begin
         col_pos_in = s1_tag_in.last_col ? '0 : col_pos_ff + ADDR_WIDTH'(1);
         if (s1_tag_in.last_col) begin
            row_pos_in = s1_tag_in.last_row ? '0 : row_pos_ff + ROW_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= COL_WIDTH'(1);
         row_count_ff    <= ROW_WIDTH'(1);
         load_pos_ff     <= '0;
         col_pos_ff      <= '0;
         row_pos_ff      <= '0;
         s1_valid_ff     <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_COLUMN_COUNT: column_count_ff <= csr_wdata[COL_WIDTH-1:0];
            CSR_ROW_COUNT:    row_count_ff    <= csr_wdata[ROW_WIDTH-1:0];
            default:          ;
         endcase
         load_pos_ff <= '0;
         col_pos_ff  <= '0;
         row_pos_ff  <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         load_pos_ff <= load_pos_in;
         col_pos_ff  <= col_pos_in;
         row_pos_ff  <= row_pos_in;
         if (advance) begin
            s1_valid_ff <= matrix_beat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (matrix_beat) begin
         s1_value_ff <= req.value;
         s1_tag_ff   <= s1_tag_in;
      end
   end

   assign wr_en    = load_beat;
   assign wr_addr  = load_pos_ff;
   assign wr_data  = req.value;
   assign rd_en    = matrix_beat;
   assign rd_addr  = col_pos_ff;
   assign s1_valid = s1_valid_ff;
   assign s1_value = s1_value_ff;
   assign s1_tag   = s1_tag_ff;

endmodule

`default_nettype wire

[rtl/mvm_mac.sv]
`default_nettype none

module mvm_mac import mvm_pkg::*; (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         advance,
   input  wire logic                         clear,
   input  wire logic                         s1_valid,
   input  wire logic signed [ELEMENT_WIDTH-1:0] s1_value,
   input  wire tag_type                      s1_tag,
   input  wire logic [ELEMENT_WIDTH-1:0]     vec_data,
   output logic                              rsp_valid,
   output rsp_type                           rsp
);

   logic                          s2_valid_ff;
   logic signed [PROD_WIDTH-1:0]  prod_ff;
   tag_type                       s2_tag_ff;
   logic signed [SUM_WIDTH-1:0]   acc_ff, sum;
   logic                          rsp_valid_ff;
   rsp_type                       rsp_ff;

   assign sum = acc_ff + SUM_WIDTH'(prod_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (clear) begin
         s2_valid_ff  <= 1'b0;
         acc_ff       <= '0;
      end else if (advance) begin
         s2_valid_ff  <= s1_valid;
         rsp_valid_ff <= s2_valid_ff && s2_tag_ff.last_col;
         if (s2_valid_ff) begin
            acc_ff <= s2_tag_ff.last_col ? '0 : sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid) begin
         prod_ff   <= s1_value * $signed(vec_data);
         s2_tag_ff <= s1_tag;
      end
      if (advance && s2_valid_ff && s2_tag_ff.last_col) begin
         rsp_ff.row_sum   <= sum;
         rsp_ff.row_index <= s2_tag_ff.row_index;
         rsp_ff.last_row  <= s2_tag_ff.last_row;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire

[rtl/matrix_vector_multiply.sv]
// Matrix-vector product, signed Q8.8 elements, signed Q26.16 row sums.
// req channel (valid/ready): cmd CMD_LOAD writes the next vector element into
// the on-chip vector store, cmd CMD_MATRIX is the next matrix element in
// row-major order. rsp channel (valid/ready): one beat per finished row with
// the row sum, row index and a last-row flag.
// csr port: write enable, index and data; index CSR_COLUMN_COUNT sets the
// vector length, CSR_ROW_COUNT the rows per product. Any write restarts
// vector loading and the product; vector contents are kept.
// Throughput: one req beat per cycle, loads and matrix elements alike, while
// rsp is not stalled. The vector store read, the multiplier register and the
// accumulator form a three-stage pipe; a row sum is registered onto rsp as the
// beat of its last matrix element leaves the multiplier register.
// Reset (synchronous): counts return to one, positions and the accumulator
// clear, the pipe empties; the vector store is not cleared.
// When rsp is stalled the whole pipe holds and req_ready drops; req_ready is
// high whenever rsp_valid is low or rsp_ready is high.
`default_nettype none

module matrix_vector_multiply import mvm_pkg::*; (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire req_type                    req,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output rsp_type                         rsp,
   input  wire logic                       csr_we,
   input  wire csr_index_type              csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   logic                            advance, accept;
   logic                            wr_en, rd_en;
   logic [ADDR_WIDTH-1:0]           wr_addr, rd_addr;
   logic [ELEMENT_WIDTH-1:0]        wr_data, vec_data;
   logic                            s1_valid;
   logic signed [ELEMENT_WIDTH-1:0] s1_value;
   tag_type                         s1_tag;

   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;
   assign accept    = req_valid && advance;

   mvm_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .advance   (advance),
      .req       (req),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .s1_valid  (s1_valid),
      .s1_value  (s1_value),
      .s1_tag    (s1_tag)
   );

   mvm_ram #(
      .DEPTH (VECTOR_DEPTH),
      .WIDTH (ELEMENT_WIDTH)
   ) u_vector_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (vec_data)
   );

   mvm_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .clear     (csr_we),
      .s1_valid  (s1_valid),
      .s1_value  (s1_value),
      .s1_tag    (s1_tag),
      .vec_data  (vec_data),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

endmodule

`default_nettype wire

[rtl/mvm_checker.sv]
`default_nettype none

module mvm_protocol_checker import mvm_pkg::*; (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   input  wire logic                       req_ready,
   input  wire req_type                    req,
   input  wire logic                       rsp_valid,
   input  wire logic                       rsp_ready,
   input  wire rsp_type                    rsp,
   input  wire logic                       csr_we,
   input  wire csr_index_type              csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
      else $error("rsp beat changed while stalled");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("req stalled without rsp backpressure");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req))
      else $error("req beat dropped or changed while waiting");

   assert property (@(posedge clock) disable iff (reset)
      csr_we |-> !rsp_valid && !$isunknown({csr_index, csr_wdata}))
      else $error("csr write with a row sum in flight");

endmodule

bind matrix_vector_multiply mvm_protocol_checker u_mvm_checker (.*);

`default_nettype wire
